// ----- rtl/bloch_octant_canonicalize_macros.svh -----
// assertion macros used by the checker file
`ifndef BLOCH_OCTANT_CANONICALIZE_MACROS_SVH
`define BLOCH_OCTANT_CANONICALIZE_MACROS_SVH

// property that must hold on every rising clock edge outside reset
`define BCANON_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication that must hold in the cycle after the antecedent
`define BCANON_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bcanon_pkg.sv -----
// shared constants, types and the arctangent table of the octant canonicaliser
`timescale 1ns / 1ps

package bcanon_pkg;

    localparam int COMPONENT_BITS_DEF   = 16;
    localparam int ANGLE_ITER_DEF       = 16;
    localparam int ATAN_LEN             = 24;
    localparam int CORDIC_GUARD         = 16;
    localparam int ACC_W                = 27;
    localparam int HEIGHT_W             = 17;
    localparam int HEIGHT_GAIN          = 227023;
    localparam int HEIGHT_GAIN_W        = 19;
    localparam int HEIGHT_MAX           = 32768;
    localparam int ANGLE_MAX            = 32768;
    localparam int ANGLE_ROUND          = 128;
    localparam int ANGLE_DROP           = 8;
    localparam int LB_W                 = 5;
    localparam logic [LB_W-1:0] LB_RESET = 5'd10;
    localparam logic [LB_W-1:0] LB_MAX   = 5'd16;
    localparam int TAG_W                = 64;
    localparam int CODE_W               = 5;

    // clifford code bit positions, one per fold step
    localparam int CODE_YZ_FIRST  = 0;
    localparam int CODE_XY_SWAP   = 1;
    localparam int CODE_YZ_SECOND = 2;
    localparam int CODE_X_FIX     = 3;
    localparam int CODE_Y_FIX     = 4;

    // side payload that rides along the cordic chain
    typedef struct packed {
        logic [TAG_W-1:0]           tag;
        logic [CODE_W-1:0]          code;
        logic signed [HEIGHT_W-1:0] height;
        logic                       zero;
    } side_t;

    // round(atan(2^-i) * 2/pi * 2^24)
    function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:       v = 27'sd8388608;
            1:       v = 27'sd4952084;
            2:       v = 27'sd2616545;
            3:       v = 27'sd1328199;
            4:       v = 27'sd666677;
            5:       v = 27'sd333664;
            6:       v = 27'sd166872;
            7:       v = 27'sd83441;
            8:       v = 27'sd41721;
            9:       v = 27'sd20861;
            10:      v = 27'sd10430;
            11:      v = 27'sd5215;
            12:      v = 27'sd2608;
            13:      v = 27'sd1304;
            14:      v = 27'sd652;
            15:      v = 27'sd326;
            16:      v = 27'sd163;
            17:      v = 27'sd81;
            18:      v = 27'sd41;
            19:      v = 27'sd20;
            20:      v = 27'sd10;
            21:      v = 27'sd5;
            22:      v = 27'sd3;
            23:      v = 27'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/bloch_octant_canonicalize.sv -----
// top level: fold stage, height and cordic set-up, cordic cell chain, output register
`timescale 1ns / 1ps
// an accepted item passes the fold, set-up, cordic cell and output registers to out_valid
// throughput: one item per cycle; each cordic cell does one micro-rotation and passes on
// stalls ripple back stage by stage, so empty stages still fill while a result waits
// reset: rst_n clears every stage valid and sets log2_buckets to 10; no clearing pass

module bloch_octant_canonicalize
    import bcanon_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = ANGLE_ITER_DEF,
    parameter int COMPONENT_BITS   = COMPONENT_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [COMPONENT_BITS-1:0] bloch_x,
    input  logic signed [COMPONENT_BITS-1:0] bloch_y,
    input  logic signed [COMPONENT_BITS-1:0] bloch_z,
    input  logic [TAG_W-1:0]                state_tag,
    // configuration
    input  logic                            cfg_we,
    input  logic [LB_W-1:0]                 cfg_data,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [15:0]                     coord_angle,
    output logic signed [HEIGHT_W-1:0]      coord_height,
    output logic [CODE_W-1:0]               clifford_code,
    output logic [15:0]                     bucket_angle,
    output logic signed [HEIGHT_W-1:0]      bucket_height,
    output logic [TAG_W-1:0]                tag_out
);

    // number of cells actually built, the table stops at 24 entries
    localparam int N  = (ANGLE_ITERATIONS < ATAN_LEN) ? ANGLE_ITERATIONS : ATAN_LEN;
    // folded component width, keeps +2^(C-1) after negation
    localparam int FW = COMPONENT_BITS + 1;
    // cordic datapath: guard bits plus headroom for gain and the sqrt(2) diagonal
    localparam int CW = FW + CORDIC_GUARD + 2;
    // height product width
    localparam int PW = FW + HEIGHT_GAIN_W + 1;
    localparam logic signed [PW-1:0] H_GAIN  = PW'(HEIGHT_GAIN);
    localparam logic signed [PW-1:0] H_ROUND = PW'(1 << 15);
    localparam logic signed [PW-1:0] H_POS   = PW'(HEIGHT_MAX);
    localparam logic signed [PW-1:0] H_NEG   = -H_POS;
    localparam logic signed [ACC_W-1:0] A_ROUND = ACC_W'(ANGLE_ROUND);
    localparam logic signed [ACC_W-1:0] A_MAX   = ACC_W'(ANGLE_MAX);

    // configuration register
    logic [LB_W-1:0] log2_buckets_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_buckets_reg <= LB_RESET;
        end
        else if (cfg_we)
        begin
            log2_buckets_reg <= cfg_data;
        end
    end

    // fold stage
    logic                 fold_valid, fold_ready;
    logic signed [FW-1:0] fold_x, fold_y, fold_z;
    logic [CODE_W-1:0]    fold_code;
    logic [TAG_W-1:0]     fold_tag;
    logic                 prep_ready;

    bcanon_fold #(
        .COMPONENT_BITS (COMPONENT_BITS)
    ) u_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .x_in      (bloch_x),
        .y_in      (bloch_y),
        .z_in      (bloch_z),
        .tag_in    (state_tag),
        .ready_in  (prep_ready),
        .ready_out (fold_ready),
        .valid_out (fold_valid),
        .x_out     (fold_x),
        .y_out     (fold_y),
        .z_out     (fold_z),
        .code_out  (fold_code),
        .tag_out   (fold_tag)
    );

    assign in_stall = !fold_ready;

    // set-up stage: height multiply with rounding and saturation, cordic operands
    logic                   prep_valid_reg;
    logic signed [CW-1:0]   prep_x_reg, prep_y_reg;
    side_t                  prep_side_reg;
    logic signed [PW-1:0]   h_prod, h_shift;
    logic signed [HEIGHT_W-1:0] h_sat;
    logic signed [CW-1:0]   x_ext, y_ext;
    side_t                  side_next;

    always_comb
    begin
        h_prod  = PW'(fold_z) * H_GAIN;
        h_shift = (h_prod + H_ROUND) >>> 16;
        if (h_shift > H_POS)
        begin
            h_sat = HEIGHT_W'(H_POS);
        end
        else if (h_shift < H_NEG)
        begin
            h_sat = HEIGHT_W'(H_NEG);
        end
        else
        begin
            h_sat = HEIGHT_W'(h_shift);
        end
        x_ext            = CW'(fold_x) <<< CORDIC_GUARD;
        y_ext            = CW'(fold_y) <<< CORDIC_GUARD;
        side_next.tag    = fold_tag;
        side_next.code   = fold_code;
        side_next.height = h_sat;
        side_next.zero   = (fold_x == '0);
    end

    // cordic chain wiring, index 0 is the set-up stage
    logic                   ch_valid [0:N];
    logic                   ch_ready [0:N];
    logic signed [CW-1:0]   ch_x     [0:N];
    logic signed [CW-1:0]   ch_y     [0:N];
    logic signed [ACC_W-1:0] ch_acc  [0:N];
    side_t                  ch_side  [0:N];
    logic                   out_ready;

    assign prep_ready = !prep_valid_reg || ch_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (prep_ready)
        begin
            prep_valid_reg <= fold_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prep_ready && fold_valid)
        begin
            prep_x_reg    <= x_ext;
            prep_y_reg    <= y_ext;
            prep_side_reg <= side_next;
        end
    end

    assign ch_valid[0] = prep_valid_reg;
    assign ch_x[0]     = prep_x_reg;
    assign ch_y[0]     = prep_y_reg;
    assign ch_acc[0]   = '0;
    assign ch_side[0]  = prep_side_reg;
    assign ch_ready[N] = out_ready;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        bcanon_cordic_cell #(
            .STAGE (i),
            .CW    (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (ch_valid[i]),
            .x_in      (ch_x[i]),
            .y_in      (ch_y[i]),
            .acc_in    (ch_acc[i]),
            .side_in   (ch_side[i]),
            .ready_in  (ch_ready[i+1]),
            .ready_out (ch_ready[i]),
            .valid_out (ch_valid[i+1]),
            .x_out     (ch_x[i+1]),
            .y_out     (ch_y[i+1]),
            .acc_out   (ch_acc[i+1]),
            .side_out  (ch_side[i+1])
        );
    end

    // output stage: angle rounding and clamp, bucket shifts
    logic                       out_valid_reg;
    logic [15:0]                angle_reg, bangle_reg;
    logic signed [HEIGHT_W-1:0] height_reg, bheight_reg;
    logic [CODE_W-1:0]          code_reg;
    logic [TAG_W-1:0]           tag_reg;
    logic signed [ACC_W-1:0]    a_round;
    logic [15:0]                angle_next;
    logic [LB_W-1:0]            lb_eff, sh;

    always_comb
    begin
        a_round = (ch_acc[N] + A_ROUND) >>> ANGLE_DROP;
        if (ch_side[N].zero || a_round[ACC_W-1])
        begin
            angle_next = '0;
        end
        else if (a_round > A_MAX)
        begin
            angle_next = 16'(A_MAX);
        end
        else
        begin
            angle_next = a_round[15:0];
        end
        // exponents above the maximum act as the maximum
        lb_eff = (log2_buckets_reg > LB_MAX) ? LB_MAX : log2_buckets_reg;
        sh     = LB_MAX - lb_eff;
    end

    assign out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= ch_valid[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && ch_valid[N])
        begin
            angle_reg   <= angle_next;
            bangle_reg  <= angle_next >> sh;
            height_reg  <= ch_side[N].height;
            bheight_reg <= ch_side[N].height >>> sh;
            code_reg    <= ch_side[N].code;
            tag_reg     <= ch_side[N].tag;
        end
    end

    assign out_valid     = out_valid_reg;
    assign coord_angle   = angle_reg;
    assign coord_height  = height_reg;
    assign clifford_code = code_reg;
    assign bucket_angle  = bangle_reg;
    assign bucket_height = bheight_reg;
    assign tag_out       = tag_reg;

endmodule

// ----- rtl/bcanon_fold.sv -----
// fold stage: conditional swaps and sign fixes into the canonical region
`timescale 1ns / 1ps

module bcanon_fold
    import bcanon_pkg::*;
#(
    parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid_in,
    input  logic signed [COMPONENT_BITS-1:0] x_in,
    input  logic signed [COMPONENT_BITS-1:0] y_in,
    input  logic signed [COMPONENT_BITS-1:0] z_in,
    input  logic [TAG_W-1:0]               tag_in,
    input  logic                           ready_in,
    output logic                           ready_out,
    output logic                           valid_out,
    output logic signed [COMPONENT_BITS:0] x_out,
    output logic signed [COMPONENT_BITS:0] y_out,
    output logic signed [COMPONENT_BITS:0] z_out,
    output logic [CODE_W-1:0]              code_out,
    output logic [TAG_W-1:0]               tag_out
);

    localparam int FW = COMPONENT_BITS + 1;

    logic              valid_reg;
    logic signed [FW-1:0] x_reg, y_reg, z_reg;
    logic signed [FW-1:0] x_next, y_next, z_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [TAG_W-1:0]  tag_reg;

    function automatic logic [FW-1:0] mag(input logic signed [FW-1:0] v);
        return v[FW-1] ? FW'(-v) : FW'(v);
    endfunction

    always_comb
    begin
        logic signed [FW-1:0] x, y, z, t;
        logic [CODE_W-1:0] c;
        x = {x_in[COMPONENT_BITS-1], x_in};
        y = {y_in[COMPONENT_BITS-1], y_in};
        z = {z_in[COMPONENT_BITS-1], z_in};
        t = '0;
        c = '0;
        if (mag(z) > mag(y))
        begin
            t = z; z = y; y = t; x = -x; c[CODE_YZ_FIRST] = 1'b1;
        end
        if (mag(y) > mag(x))
        begin
            t = x; x = y; y = t; z = -z; c[CODE_XY_SWAP] = 1'b1;
        end
        if (mag(z) > mag(y))
        begin
            t = z; z = y; y = t; x = -x; c[CODE_YZ_SECOND] = 1'b1;
        end
        if (x[FW-1])
        begin
            x = -x; y = -y; c[CODE_X_FIX] = 1'b1;
        end
        if (y[FW-1])
        begin
            y = -y; z = -z; c[CODE_Y_FIX] = 1'b1;
        end
        x_next    = x;
        y_next    = y;
        z_next    = z;
        code_next = c;
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            code_reg <= code_next;
            tag_reg  <= tag_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign code_out  = code_reg;
    assign tag_out   = tag_reg;

endmodule

// ----- rtl/bcanon_cordic_cell.sv -----
// one vectoring cordic micro-rotation with its own pipeline register
`timescale 1ns / 1ps

module bcanon_cordic_cell
    import bcanon_pkg::*;
#(
    parameter int STAGE = 0,
    parameter int CW    = COMPONENT_BITS_DEF + 19
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  valid_in,
    input  logic signed [CW-1:0]  x_in,
    input  logic signed [CW-1:0]  y_in,
    input  logic signed [ACC_W-1:0] acc_in,
    input  side_t                 side_in,
    input  logic                  ready_in,
    output logic                  ready_out,
    output logic                  valid_out,
    output logic signed [CW-1:0]  x_out,
    output logic signed [CW-1:0]  y_out,
    output logic signed [ACC_W-1:0] acc_out,
    output side_t                 side_out
);

    localparam logic signed [ACC_W-1:0] ATAN_I = atan_entry(STAGE);

    logic                  valid_reg;
    logic signed [CW-1:0]  x_reg, y_reg, x_next, y_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    side_t                 side_reg;

    always_comb
    begin
        if (!y_in[CW-1])
        begin
            x_next   = x_in + (y_in >>> STAGE);
            y_next   = y_in - (x_in >>> STAGE);
            acc_next = acc_in + ATAN_I;
        end
        else
        begin
            x_next   = x_in - (y_in >>> STAGE);
            y_next   = y_in + (x_in >>> STAGE);
            acc_next = acc_in - ATAN_I;
        end
    end

    assign ready_out = !valid_reg || ready_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_out)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_out && valid_in)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign acc_out   = acc_reg;
    assign side_out  = side_reg;

endmodule

// ----- rtl/bcanon_checker.sv -----
// port-level checker for the octant canonicaliser and its bind
`timescale 1ns / 1ps
`include "bloch_octant_canonicalize_macros.svh"

module bcanon_checker
    import bcanon_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [15:0]                coord_angle,
    input  logic signed [HEIGHT_W-1:0] coord_height,
    input  logic [15:0]                bucket_angle,
    input  logic [TAG_W-1:0]           tag_out
);

    // a stalled result stays offered
    `BCANON_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")

    // a stalled result keeps its tag and angle
    `BCANON_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(tag_out) && $stable(coord_angle), "stalled result changed")

    // angle clamp
    `BCANON_ASSERT(a_angle_range, clk, rst_n, !out_valid || (coord_angle <= 16'd32768), "angle above one half")

    // height saturation
    `BCANON_ASSERT(a_height_range, clk, rst_n, !out_valid || ((coord_height <= 17'sd32768) && (coord_height >= -17'sd32768)), "height out of range")

    // angle bucket index never exceeds the angle it is taken from
    `BCANON_ASSERT(a_bucket_le, clk, rst_n, !out_valid || (bucket_angle <= coord_angle), "angle bucket above angle")

endmodule

bind bloch_octant_canonicalize bcanon_checker u_bcanon_checker (.*);
